/* rtl/wwtm_pkg.sv */
`timescale 1ns / 1ps

package wwtm_pkg;

    // register map (byte address = 4 * index)
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_WRAP_WIDTH = 1'b0;
    localparam logic REG_LINE_PITCH = 1'b1;

    localparam logic [15:0] WRAP_WIDTH_RESET = 16'hFFFF;
    localparam logic [7:0]  LINE_PITCH_RESET = 8'd16;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // codepoint classes
    localparam logic [20:0] CP_NEWLINE   = 21'h00000A;
    localparam logic [20:0] CP_SPACE     = 21'h000020;
    localparam logic [20:0] CJK_UNI_LO   = 21'h004E00;
    localparam logic [20:0] CJK_UNI_HI   = 21'h009FFF;
    localparam logic [20:0] CJK_EXTA_LO  = 21'h003400;
    localparam logic [20:0] CJK_EXTA_HI  = 21'h004DBF;
    localparam logic [20:0] CJK_PUNCT_LO = 21'h003000;
    localparam logic [20:0] CJK_PUNCT_HI = 21'h00303F;

    localparam logic [1:0] CLS_WORD    = 2'd0;
    localparam logic [1:0] CLS_SPACE   = 2'd1;
    localparam logic [1:0] CLS_CJK     = 2'd2;
    localparam logic [1:0] CLS_NEWLINE = 2'd3;

    typedef struct packed {
        logic [20:0] codepoint;
        logic [7:0]  advance;
        logic        last_char;
    } in_item_t;

    typedef struct packed {
        logic [15:0] text_width;
        logic [23:0] text_height;
        logic [15:0] line_count;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] advance;
        logic       last_char;
    } op_t;

endpackage

/* rtl/wwtm_front.sv */
`timescale 1ns / 1ps

module wwtm_front import wwtm_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     push_valid,
    input  logic     push_ready,
    output op_t      push_op
);

    logic is_cjk;

    always_comb begin
        is_cjk = (s_item.codepoint inside {[CJK_UNI_LO:CJK_UNI_HI]})
              || (s_item.codepoint inside {[CJK_EXTA_LO:CJK_EXTA_HI]})
              || (s_item.codepoint inside {[CJK_PUNCT_LO:CJK_PUNCT_HI]});
    end

    always_comb begin
        if (s_item.codepoint == CP_NEWLINE) begin
            push_op.cls = CLS_NEWLINE;
        end else if (is_cjk) begin
            push_op.cls = CLS_CJK;
        end else if (s_item.codepoint == CP_SPACE) begin
            push_op.cls = CLS_SPACE;
        end else begin
            push_op.cls = CLS_WORD;
        end
        push_op.advance   = s_item.advance;
        push_op.last_char = s_item.last_char;
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

/* rtl/wwtm_queue.sv */
`timescale 1ns / 1ps

module wwtm_queue import wwtm_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_op
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/wwtm_back.sv */
`timescale 1ns / 1ps

module wwtm_back import wwtm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] wrap_width,
    input  logic [7:0]  line_pitch,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  op_t         pop_op,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    typedef struct packed {
        logic [15:0] line_width;
        logic [15:0] word_width;
        logic        in_word;
        logic [15:0] widest_line;
        logic [15:0] lines_so_far;
    } layout_t;

    localparam layout_t LAYOUT_CLEAR = '{
        line_width:   16'd0,
        word_width:   16'd0,
        in_word:      1'b0,
        widest_line:  16'd0,
        lines_so_far: 16'd1
    };

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? SAT16 : s[15:0];
    endfunction

    function automatic logic overflows(input logic [15:0] line, input logic [15:0] add,
                                       input logic [15:0] wrap);
        logic [16:0] s;
        s = {1'b0, line} + {1'b0, add};
        return (line != '0) && (s > {1'b0, wrap});
    endfunction

    function automatic layout_t close_line(input layout_t st);
        layout_t r;
        r = st;
        if (st.line_width > st.widest_line) begin
            r.widest_line = st.line_width;
        end
        r.line_width = '0;
        if (st.lines_so_far != SAT16) begin
            r.lines_so_far = st.lines_so_far + 1'b1;
        end
        return r;
    endfunction

    function automatic layout_t commit_word(input layout_t st, input logic [15:0] wrap);
        layout_t r;
        r = st;
        if (st.in_word) begin
            if (overflows(st.line_width, st.word_width, wrap)) begin
                r = close_line(st);
            end
            r.line_width = sat_add(r.line_width, st.word_width);
            r.word_width = '0;
            r.in_word    = 1'b0;
        end
        return r;
    endfunction

    layout_t     lay_reg, lay_next;
    layout_t     upd;
    logic [15:0] adv16;
    logic        step;

    // result stage between the layout update and the pitch multiply
    logic        res_valid_reg;
    logic [15:0] res_width_reg;
    logic [15:0] res_lines_reg;
    logic        res_ready;

    logic        m_valid_reg;
    out_item_t   m_item_reg;
    logic        out_load;

    assign out_load  = res_valid_reg && (!m_valid_reg || m_ready);
    assign res_ready = !res_valid_reg || out_load;
    assign pop_ready = !pop_op.last_char || res_ready;
    assign step      = pop_valid && pop_ready;
    assign adv16     = {8'd0, pop_op.advance};

    always_comb begin
        upd = lay_reg;
        case (pop_op.cls)
            CLS_NEWLINE: begin
                upd = close_line(commit_word(lay_reg, wrap_width));
            end
            CLS_CJK: begin
                upd = commit_word(lay_reg, wrap_width);
                if (overflows(upd.line_width, adv16, wrap_width)) begin
                    upd = close_line(upd);
                end
                upd.line_width = sat_add(upd.line_width, adv16);
            end
            CLS_SPACE: begin
                upd = commit_word(lay_reg, wrap_width);
                if (overflows(upd.line_width, adv16, wrap_width)) begin
                    upd = close_line(upd);
                end else begin
                    upd.line_width = sat_add(upd.line_width, adv16);
                end
            end
            default: begin
                upd.word_width = sat_add(lay_reg.word_width, adv16);
                upd.in_word    = 1'b1;
            end
        endcase
        if (pop_op.last_char) begin
            upd = commit_word(upd, wrap_width);
            if (upd.line_width > upd.widest_line) begin
                upd.widest_line = upd.line_width;
            end
        end
        lay_next = (pop_op.last_char) ? LAYOUT_CLEAR : upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lay_reg       <= LAYOUT_CLEAR;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (step) begin
                lay_reg <= lay_next;
            end
            if (step && pop_op.last_char) begin
                res_valid_reg <= 1'b1;
            end else if (out_load) begin
                res_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && pop_op.last_char) begin
            res_width_reg <= upd.widest_line;
            res_lines_reg <= upd.lines_so_far;
        end
        if (out_load) begin
            m_item_reg.text_width  <= res_width_reg;
            m_item_reg.line_count  <= res_lines_reg;
            m_item_reg.text_height <= 24'(res_lines_reg) * 24'(line_pitch);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* rtl/word_wrap_text_measurer_core.sv */
`timescale 1ns / 1ps

// Greedy word-wrap text measurer. Feed one decoded codepoint per request with
// its glyph advance; the block lays the text onto lines no wider than
// wrap_width unless one word or glyph alone is wider (newline forces a break,
// CJK codepoints break on their own, a space that would overflow starts a new
// line and is dropped, other codepoints build a word that moves whole to a new
// line when it would overflow). The request marked last_char yields one
// result: widest line, line count times line_pitch and line count, widths and
// counts saturating at 65535; the layout state then clears for the next string
// while the registers keep their values. Throughput is one codepoint per clock,
// except that a last_char request waits while the result stage is still full.
// A result passes from the layout update into the result stage, then into the
// output register that holds the line-pitch multiply. Registers sit at byte
// address 0 (wrap_width, 16 bit, reset 65535) and 4 (line_pitch, 8 bit, reset
// 16); write them only while no string is in flight.

module word_wrap_text_measurer_core import wwtm_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    // codepoint requests
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    // measurement results
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_item,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] wrap_width_reg;
    logic [7:0]  line_pitch_reg;
    logic        reg_write;

    // front to queue
    logic push_valid, push_ready;
    op_t  push_op;

    // queue to back
    logic pop_valid, pop_ready;
    op_t  pop_op;

    // register port: always ready, word addressed by paddr[2]
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_width_reg <= WRAP_WIDTH_RESET;
            line_pitch_reg <= LINE_PITCH_RESET;
        end else if (reg_write) begin
            case (paddr[2])
                REG_WRAP_WIDTH: begin
                    wrap_width_reg <= pwdata[15:0];
                end
                REG_LINE_PITCH: begin
                    line_pitch_reg <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WRAP_WIDTH: prdata = {16'd0, wrap_width_reg};
            REG_LINE_PITCH: prdata = {24'd0, line_pitch_reg};
            default:        prdata = '0;
        endcase
    end

    // front: classify each codepoint as word, space, cjk or newline
    wwtm_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // short queue so the front takes requests until it fills while results stall
    wwtm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // back: running line and word widths, line breaks, result registers
    wwtm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wrap_width (wrap_width_reg),
        .line_pitch (line_pitch_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

/* tb/sv/word_wrap_text_measurer_core_tb.sv */
`timescale 1ns / 1ps

module word_wrap_text_measurer_core_tb;
    import wwtm_pkg::*;

    // byte addresses of the two layout registers
    localparam logic [ADDR_W-1:0] WRAP_ADDR  = {REG_WRAP_WIDTH, 2'b00};
    localparam logic [ADDR_W-1:0] PITCH_ADDR = {REG_LINE_PITCH, 2'b00};

    // every block input starts at a known value
    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_item  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_item;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // idle controls for the request and result sides
    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int stall_left     = 0;
    int err_count      = 0;
    int items_sent     = 0;

    // measurements still owed by the block, oldest first
    out_item_t pending_measures[$];

    // layout model: register copies and running line state
    int unsigned wrap_lim = WRAP_WIDTH_RESET;
    int unsigned pitch_px = LINE_PITCH_RESET;
    int unsigned cur_line_w;
    int unsigned cur_word_w;
    int unsigned widest_w;
    int unsigned line_total;
    bit          word_open;

    word_wrap_text_measurer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // layout model
    // ---------------------------------------------------------------

    function automatic int unsigned sat16(input int unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    // unified ideographs, extension a and cjk punctuation
    function automatic bit is_cjk(input logic [20:0] cp);
        return (cp >= CJK_UNI_LO && cp <= CJK_UNI_HI) ||
               (cp >= CJK_EXTA_LO && cp <= CJK_EXTA_HI) ||
               (cp >= CJK_PUNCT_LO && cp <= CJK_PUNCT_HI);
    endfunction

    function automatic void clear_layout();
        cur_line_w = 0;
        cur_word_w = 0;
        word_open  = 1'b0;
        widest_w   = 0;
        line_total = 1;
    endfunction

    function automatic void break_line();
        if (cur_line_w > widest_w) widest_w = cur_line_w;
        cur_line_w = 0;
        if (line_total < 65535) line_total++;
    endfunction

    // pending word moves to a new line only if it overflows a non-empty one;
    // the overflow test uses the unsaturated sum
    function automatic void place_word();
        if (!word_open) return;
        if (cur_line_w > 0 && cur_line_w + cur_word_w > wrap_lim) break_line();
        cur_line_w = sat16(cur_line_w + cur_word_w);
        cur_word_w = 0;
        word_open  = 1'b0;
    endfunction

    // apply one accepted request; queue a measurement on the last codepoint
    function automatic void lay_out_codepoint(input in_item_t it);
        out_item_t m;
        if (it.codepoint == CP_NEWLINE) begin
            place_word();
            break_line();
        end else if (is_cjk(it.codepoint)) begin
            place_word();
            if (cur_line_w > 0 && cur_line_w + it.advance > wrap_lim) break_line();
            cur_line_w = sat16(cur_line_w + it.advance);
        end else if (it.codepoint == CP_SPACE) begin
            // an overflowing space breaks the line and is dropped
            place_word();
            if (cur_line_w > 0 && cur_line_w + it.advance > wrap_lim) begin
                break_line();
            end else begin
                cur_line_w = sat16(cur_line_w + it.advance);
            end
        end else begin
            // everything else, out-of-range and zero included, is a word char
            cur_word_w = sat16(cur_word_w + it.advance);
            word_open  = 1'b1;
        end
        if (it.last_char) begin
            place_word();
            if (cur_line_w > widest_w) widest_w = cur_line_w;
            m.text_width  = widest_w[15:0];
            m.text_height = 24'(line_total * pitch_px);
            m.line_count  = line_total[15:0];
            pending_measures.push_back(m);
            // a new string starts with the next request
            clear_layout();
        end
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // valid stays high between back-to-back requests; here it only drops for a gap
    task automatic send_codepoint(input logic [20:0] cp, input logic [7:0] adv,
                                  input bit last);
        in_item_t it;
        it.codepoint = cp;
        it.advance   = adv;
        it.last_char = last;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        lay_out_codepoint(it);
    endtask

    // hold off requests until every owed measurement is out, then let the
    // three-stage pipe settle
    task automatic wait_for_measures();
        s_valid <= 1'b0;
        while (pending_measures.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reg_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // drain, write both registers (junk in the unused upper bits), read back
    task automatic set_layout_config(input int unsigned wrap, input int unsigned pitch);
        logic [31:0] rd;
        wait_for_measures();
        reg_write(WRAP_ADDR, {16'($urandom()), 16'(wrap)});
        reg_write(PITCH_ADDR, {24'($urandom()), 8'(pitch)});
        wrap_lim = wrap & 16'hFFFF;
        pitch_px = pitch & 8'hFF;
        reg_read(WRAP_ADDR, rd);
        if (rd[15:0] !== 16'(wrap_lim))
            flag_mismatch($sformatf("wrap_width reads %0d, wrote %0d", rd[15:0], wrap_lim));
        reg_read(PITCH_ADDR, rd);
        if (rd[7:0] !== 8'(pitch_px))
            flag_mismatch($sformatf("line_pitch reads %0d, wrote %0d", rd[7:0], pitch_px));
    endtask

    // ---------------------------------------------------------------
    // result side: random stall bursts and the scoreboard
    // ---------------------------------------------------------------

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_measures.size() == 0) begin
                flag_mismatch($sformatf("unexpected measurement w=%0d h=%0d n=%0d",
                              m_item.text_width, m_item.text_height, m_item.line_count));
            end else begin
                want = pending_measures.pop_front();
                if (m_item.text_width !== want.text_width)
                    flag_mismatch($sformatf("text_width %0d, want %0d",
                                  m_item.text_width, want.text_width));
                if (m_item.text_height !== want.text_height)
                    flag_mismatch($sformatf("text_height %0d, want %0d",
                                  m_item.text_height, want.text_height));
                if (m_item.line_count !== want.line_count)
                    flag_mismatch($sformatf("line_count %0d, want %0d",
                                  m_item.line_count, want.line_count));
            end
        end
        // random stall bursts
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // registers come out of reset at their documented values
    task automatic test_register_reset();
        logic [31:0] rd;
        reg_read(WRAP_ADDR, rd);
        if (rd[15:0] !== WRAP_WIDTH_RESET)
            flag_mismatch($sformatf("wrap_width reset value %0d", rd[15:0]));
        reg_read(PITCH_ADDR, rd);
        if (rd[7:0] !== LINE_PITCH_RESET)
            flag_mismatch($sformatf("line_pitch reset value %0d", rd[7:0]));
    endtask

    // word overflow, dropped space, cjk range edges and newline as last item
    task automatic test_char_classes();
        set_layout_config(40, 20);
        send_codepoint(21'h61, 8'd15, 1'b0);
        send_codepoint(21'h62, 8'd15, 1'b0);
        send_codepoint(CP_SPACE, 8'd8, 1'b0);
        send_codepoint(21'h63, 8'd15, 1'b0);
        // this word no longer fits and moves down
        send_codepoint(21'h64, 8'd15, 1'b0);
        // overflowing space: break and drop
        send_codepoint(CP_SPACE, 8'd20, 1'b0);
        // cjk edges and the neighbors just outside all but the low unified edge
        send_codepoint(CJK_PUNCT_LO, 8'd12, 1'b0);
        send_codepoint(CJK_PUNCT_HI, 8'd12, 1'b0);
        send_codepoint(CJK_PUNCT_HI + 21'd1, 8'd12, 1'b0);
        send_codepoint(CJK_EXTA_LO - 21'd1, 8'd12, 1'b0);
        send_codepoint(CJK_EXTA_LO, 8'd12, 1'b0);
        send_codepoint(CJK_EXTA_HI, 8'd12, 1'b0);
        send_codepoint(CJK_EXTA_HI + 21'd1, 8'd12, 1'b0);
        send_codepoint(CJK_UNI_LO, 8'd12, 1'b0);
        send_codepoint(CJK_UNI_HI, 8'd12, 1'b0);
        send_codepoint(CJK_UNI_HI + 21'd1, 8'd12, 1'b0);
        send_codepoint(CJK_PUNCT_LO - 21'd1, 8'd12, 1'b0);
        // trailing newline counts the final empty line
        send_codepoint(CP_NEWLINE, 8'd12, 1'b1);
    endtask

    // zero and all-ones fields against both register extremes
    task automatic test_field_extremes();
        set_layout_config(0, 0);
        send_codepoint(21'h000000, 8'hFF, 1'b0);
        send_codepoint(21'h1FFFFF, 8'h00, 1'b1);
        send_codepoint(CP_SPACE, 8'hFF, 1'b1);
        send_codepoint(CP_NEWLINE, 8'h00, 1'b1);
        set_layout_config(65535, 255);
        send_codepoint(21'h41, 8'hFF, 1'b0);
        send_codepoint(CJK_UNI_HI, 8'hFF, 1'b0);
        send_codepoint(CP_NEWLINE, 8'hFF, 1'b1);
    endtask

    // word width and line width pinned at 65535, spaces overflowing a full line
    task automatic test_saturation();
        int k;
        set_layout_config(65535, 255);
        for (k = 0; k < 260; k++) send_codepoint(21'h41, 8'hFF, k == 259);
        for (k = 0; k < 260; k++) send_codepoint(CP_SPACE, 8'hFF, k == 259);
    endtask

    // one string of mostly text-like content, ending on last_char
    task automatic send_random_string();
        int          n;
        int          k;
        int          kind;
        bit          junk;
        logic [20:0] cp;
        logic [7:0]  adv;
        // a few strings are pure noise
        junk = ($urandom_range(0, 19) == 0);
        n    = $urandom_range(1, 40);
        for (k = 0; k < n; k++) begin
            kind = junk ? 99 : $urandom_range(0, 99);
            if (kind < 55) begin
                cp = 21'($urandom_range(33, 126));
            end else if (kind < 70) begin
                cp = CP_SPACE;
            end else if (kind < 82) begin
                case ($urandom_range(0, 2))
                    0: cp = 21'($urandom_range(CJK_UNI_LO, CJK_UNI_HI));
                    1: cp = 21'($urandom_range(CJK_EXTA_LO, CJK_EXTA_HI));
                    default: cp = 21'($urandom_range(CJK_PUNCT_LO, CJK_PUNCT_HI));
                endcase
            end else if (kind < 88) begin
                cp = CP_NEWLINE;
            end else begin
                cp = 21'($urandom());
            end
            adv = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 24));
            send_codepoint(cp, adv, k == n - 1);
        end
    endtask

    // phases over several register settings; the last one without gaps or stalls
    task automatic test_random_strings();
        int ph;
        int goal;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_layout_config($urandom_range(20, 200), $urandom_range(1, 255));
                1: set_layout_config(0, 255);
                2: set_layout_config(65535, 0);
                3: set_layout_config($urandom_range(40, 400), $urandom_range(0, 255));
                4: set_layout_config(1, 1);
                default: begin
                    set_layout_config($urandom_range(30, 300), $urandom_range(0, 255));
                    src_gaps_on    = 1'b0;
                    sink_stalls_on = 1'b0;
                end
            endcase
            goal = items_sent + 100;
            while (items_sent < goal) begin
                send_random_string();
                // now and then hold the sender until the pipe is empty
                if ($urandom_range(0, 24) == 0) wait_for_measures();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        clear_layout();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_char_classes();
        test_field_extremes();
        test_saturation();
        test_random_strings();
        // drain the last measurements, then a few quiet cycles
        s_valid <= 1'b0;
        while (pending_measures.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/wwtm_pkg.sv
rtl/wwtm_front.sv
rtl/wwtm_queue.sv
rtl/wwtm_back.sv
rtl/word_wrap_text_measurer_core.sv
tb/sv/word_wrap_text_measurer_core_tb.sv
